FILE: hw/rtl/bcgd_pkg.sv
// Shared types and constants for the button click gesture decoder.
// No dependencies; used by bcgd_step and button_click_gesture_decoder_core.
package bcgd_pkg;

	localparam int unsigned HOLD_W    = 10;
	localparam int unsigned COUNT_W   = 11;
	localparam int unsigned GESTURE_W = 2;

	localparam logic [HOLD_W-1:0]    HOLD_RESET = HOLD_W'(50);
	localparam logic [COUNT_W-1:0]   COUNT_MAX  = {COUNT_W{1'b1}};

	localparam logic [GESTURE_W-1:0] G_LONG   = 2'd0;
	localparam logic [GESTURE_W-1:0] G_SINGLE = 2'd1;
	localparam logic [GESTURE_W-1:0] G_DOUBLE = 2'd2;
	localparam logic [GESTURE_W-1:0] G_TRIPLE = 2'd3;

	typedef enum logic [6:0] {
		PH_IDLE   = 7'b0000001,
		PH_PRESS1 = 7'b0000010,
		PH_REL1   = 7'b0000100,
		PH_PRESS2 = 7'b0001000,
		PH_REL2   = 7'b0010000,
		PH_PRESS3 = 7'b0100000,
		PH_WAIT   = 7'b1000000
	} phase_t;

	typedef struct packed {
		phase_t             phase;
		logic [COUNT_W-1:0] count;
		logic [HOLD_W-1:0]  hold;
		logic               pressed;
	} step_in_t;

	typedef struct packed {
		phase_t               phase;
		logic [COUNT_W-1:0]   count;
		logic                 emit;
		logic [GESTURE_W-1:0] gesture;
	} step_out_t;

endpackage

FILE: hw/rtl/bcgd_step.sv
// Next-state logic for one sampled button level: phase walk, tick counter, timeout.
// Depends on bcgd_pkg.
module bcgd_step (
	input  bcgd_pkg::step_in_t  si,
	output bcgd_pkg::step_out_t so
);
	import bcgd_pkg::*;

	phase_t             ph;
	logic [COUNT_W-1:0] cnt;
	logic [COUNT_W-1:0] cnt_inc;
	logic               expect_pressed;
	logic               counting;

	always_comb begin
		so             = '0;
		so.phase       = si.phase;
		so.count       = si.count;
		ph             = si.phase;
		cnt            = si.count;
		counting       = 1'b1;
		expect_pressed = 1'b0;
		cnt_inc        = '0;

		case (si.phase)
			PH_WAIT: begin
				counting = 1'b0;
				if (!si.pressed) begin
					so.phase = PH_IDLE;
					so.count = '0;
				end
			end
			PH_PRESS1, PH_REL1, PH_PRESS2, PH_REL2, PH_PRESS3: begin
			end
			default: begin
				if (!si.pressed) begin
					counting = 1'b0;
					so.phase = PH_IDLE;
				end else begin
					ph  = PH_PRESS1;
					cnt = '0;
				end
			end
		endcase

		if (counting) begin
			expect_pressed = (ph == PH_PRESS1) || (ph == PH_PRESS2) || (ph == PH_PRESS3);
			if (si.pressed != expect_pressed) begin
				case (ph)
					PH_PRESS1: ph = PH_REL1;
					PH_REL1:   ph = PH_PRESS2;
					PH_PRESS2: ph = PH_REL2;
					PH_REL2:   ph = PH_PRESS3;
					default:   ph = PH_IDLE;
				endcase
				cnt = '0;
			end
			if (si.phase == PH_PRESS3 && !si.pressed) begin
				// third release
				so.phase   = PH_IDLE;
				so.count   = '0;
				so.emit    = 1'b1;
				so.gesture = G_TRIPLE;
			end else begin
				cnt_inc = (cnt == COUNT_MAX) ? cnt : cnt + COUNT_W'(1);
				if (cnt_inc > {1'b0, si.hold}) begin
					so.emit  = 1'b1;
					so.count = '0;
					case (ph)
						PH_PRESS1: begin
							so.gesture = G_LONG;
							so.phase   = PH_WAIT;
						end
						PH_REL1: begin
							so.gesture = G_SINGLE;
							so.phase   = PH_IDLE;
						end
						PH_PRESS2: begin
							so.gesture = G_DOUBLE;
							so.phase   = PH_WAIT;
						end
						PH_REL2: begin
							so.gesture = G_DOUBLE;
							so.phase   = PH_IDLE;
						end
						default: begin
							so.gesture = G_TRIPLE;
							so.phase   = PH_WAIT;
						end
					endcase
				end else begin
					so.phase = ph;
					so.count = cnt_inc;
				end
			end
		end
	end

endmodule

FILE: hw/rtl/button_click_gesture_decoder_core.sv
// Top level of the button click gesture decoder: input stage, phase state, result register.
// Depends on bcgd_pkg and bcgd_step.
//
// One sampled button level per transaction, one transaction per cycle sustained while no
// gesture is held. A sample is registered in the input stage, then the phase and tick
// counter advance and any gesture lands in the output register. A held gesture on the
// master side stalls the input stage until it is taken. hold_limit is written through
// cfg_wen/cfg_wdata and resets to 50.
module button_click_gesture_decoder_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_axis_tvalid,
	output logic       s_axis_tready,
	input  logic [7:0] s_axis_tdata,  // [0] button_pressed, [7:1] zero
	output logic       m_axis_tvalid,
	input  logic       m_axis_tready,
	output logic [7:0] m_axis_tdata,  // [1:0] gesture, [7:2] zero
	input  logic       cfg_wen,
	input  logic [9:0] cfg_wdata      // hold_limit
);
	import bcgd_pkg::*;

	logic                 valid_s1;
	logic                 pressed_s1;
	logic                 advance;
	phase_t               phase_q;
	logic [COUNT_W-1:0]   count_q;
	logic [HOLD_W-1:0]    hold_q;
	logic                 m_valid_q;
	logic [GESTURE_W-1:0] gesture_q;
	step_in_t             si;
	step_out_t            so;

	assign advance       = !m_valid_q || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	assign si.phase   = phase_q;
	assign si.count   = count_q;
	assign si.hold    = hold_q;
	assign si.pressed = pressed_s1;

	bcgd_step u_step (
		.si (si),
		.so (so)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			pressed_s1 <= s_axis_tdata[0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hold_q <= HOLD_RESET;
		end else if (cfg_wen) begin
			hold_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			count_q <= '0;
		end else if (valid_s1 && advance) begin
			phase_q <= so.phase;
			count_q <= so.count;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_valid_q <= 1'b0;
		end else if (valid_s1 && advance && so.emit) begin
			m_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			m_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1 && advance && so.emit) begin
			gesture_q <= so.gesture;
		end
	end

	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = {{(8 - GESTURE_W){1'b0}}, gesture_q};

`ifndef SYNTHESIS
	a_idle_count_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_IDLE || phase_q == PH_WAIT) |-> (count_q == '0))
		else $error("count not cleared in idle or wait");

	a_stall_holds_s1: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> (valid_s1 && $stable(pressed_s1)))
		else $error("stalled sample lost");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(m_valid_q && !m_axis_tready) |=> (m_valid_q && $stable(gesture_q)))
		else $error("pending gesture overwritten");

	a_state_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> ($stable(phase_q) && $stable(count_q)))
		else $error("state moved without a sample");
`endif

endmodule
